// ===== design/tkcv_pkg.sv =====
// Package for the tile category vote block: payload structs, constants,
// and the controller/datapath command and status structs. No dependencies.
package tkcv_pkg;

  localparam int MaxK      = 8;
  localparam int NumCat    = 16;
  localparam int KW        = $clog2(MaxK);
  localparam int CW        = $clog2(NumCat);
  localparam int CntW      = 11;
  localparam int CountMax  = 2047;
  localparam int Tol       = 18;
  localparam int OpaqueA   = 128;
  localparam int LayerCost = 12;
  localparam int NearR     = 5;
  localparam int NearBonus = 8;

  localparam logic [1:0] RegMinPct = 2'd0;
  localparam logic [1:0] RegNeigh  = 2'd1;
  localparam logic [1:0] RegCols   = 2'd2;
  localparam logic [1:0] RegPix    = 2'd3;

  typedef struct packed {
    logic [31:0]       query_pixel;
    logic [31:0]       ref_pixel;
    logic [11:0]       query_tile;
    logic [11:0]       ref_tile;
    logic [3:0]        ref_category;
    logic signed [3:0] ref_layer;
    logic signed [3:0] query_layer;
    logic              last_pixel;
    logic              last_ref;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [3:0]        winner_category;
    logic signed [7:0] peak_percent;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic accum;      // fold the held pixel pair into the counts
    logic div_start;  // latch reference data, start divide and bonus
    logic div_step;   // one quotient bit
    logic score;      // apply adjustments, decide candidacy
    logic ins_step;   // one top-list compare/shift step
    logic vote_clr;   // clear the vote tallies
    logic vote_add;   // fold one top entry into tallies
    logic pick_step;  // examine one category
    logic finish;     // register result, clear top list
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;       // reference not scored
    logic cand;       // score qualifies for the list
    logic ins_done;
    logic div_done;
    logic add_done;
    logic pick_done;
  } stat_t;

endpackage

// ===== design/tkcv_datapath.sv =====
// Datapath for the tile category vote: counters, serial divider, top list,
// tallies and winner search. Uses tkcv_pkg; driven by tkcv_ctrl.
module tkcv_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkcv_pkg::in_word_t  item_i,
  input  tkcv_pkg::cmd_t      cmd_i,
  input  logic [6:0]          min_percent_i,
  input  logic [3:0]          neighbours_i,
  input  logic [11:0]         sheet_columns_i,
  input  logic [10:0]         tile_pixels_i,
  output tkcv_pkg::stat_t     stat_o,
  output tkcv_pkg::out_word_t res_o
);
  import tkcv_pkg::*;

  // ---- pixel accumulation
  logic [CntW-1:0] union_q, match_q, union_n, match_n;
  logic [7:0] qa, ra;
  logic       qo, ro, mt;

  function automatic logic close8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? a - b : b - a;
    return d <= 8'(Tol);
  endfunction

  // counts with the held pair folded in, saturating
  always_comb begin
    qa = item_i.query_pixel[31:24];
    ra = item_i.ref_pixel[31:24];
    qo = qa >= 8'(OpaqueA);
    ro = ra >= 8'(OpaqueA);
    mt = close8(qa, ra);
    if (qo && ro)
      mt = mt && close8(item_i.query_pixel[23:16], item_i.ref_pixel[23:16])
              && close8(item_i.query_pixel[15:8], item_i.ref_pixel[15:8])
              && close8(item_i.query_pixel[7:0], item_i.ref_pixel[7:0]);
    union_n = union_q;
    match_n = match_q;
    if (qo || ro) begin
      if (union_q != CntW'(CountMax)) union_n = union_q + 1'b1;
      if (mt && match_q != CntW'(CountMax)) match_n = match_q + 1'b1;
    end
  end

  // ---- reference latch and serial divider (quotient of match*100/union,
  // also quotient/remainder of the tile indices by sheet_columns)
  logic [CntW-1:0]  un_q;
  logic [17:0]      num_q;   // match*100 < 2^18
  logic [17:0]      rem_q;
  logic [6:0]       quo_q;
  logic [11:0]      qtn_q, rtn_q, qtr_q, rtr_q, qtq_q, rtq_q;
  logic [4:0]       bit_q;
  logic [CW-1:0]    cat_q;
  logic signed [3:0] ql_q, rl_q;
  logic [17:0]      rem_sh;
  logic [12:0]      qsh, rsh;
  logic             skip_c;
  logic [CntW-1:0]  min_union;

  assign min_union = CntW'(tile_pixels_i >> 3);
  assign skip_c = (item_i.query_tile == item_i.ref_tile) || (union_n == '0) ||
                  (union_n < min_union);

  always_comb begin
    rem_sh = {rem_q[16:0], num_q[17]};
    qsh    = {qtr_q, qtn_q[11]};
    rsh    = {rtr_q, rtn_q[11]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      un_q  <= union_n;
      num_q <= 18'(match_n) * 18'd100;
      rem_q <= '0;
      quo_q <= '0;
      qtn_q <= item_i.query_tile;
      rtn_q <= item_i.ref_tile;
      qtr_q <= '0;
      rtr_q <= '0;
      qtq_q <= '0;
      rtq_q <= '0;
      cat_q <= item_i.ref_category[CW-1:0];
      ql_q  <= item_i.query_layer;
      rl_q  <= item_i.ref_layer;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[16:0], 1'b0};
      if (rem_sh >= 18'(un_q)) begin
        rem_q <= rem_sh - 18'(un_q);
        quo_q <= {quo_q[5:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[5:0], 1'b0};
      end
      if (bit_q < 5'd12) begin
        qtn_q <= {qtn_q[10:0], 1'b0};
        rtn_q <= {rtn_q[10:0], 1'b0};
        if (qsh >= 13'(sheet_columns_i)) begin
          qtr_q <= 12'(qsh - 13'(sheet_columns_i));
          qtq_q <= {qtq_q[10:0], 1'b1};
        end else begin
          qtr_q <= qsh[11:0];
          qtq_q <= {qtq_q[10:0], 1'b0};
        end
        if (rsh >= 13'(sheet_columns_i)) begin
          rtr_q <= 12'(rsh - 13'(sheet_columns_i));
          rtq_q <= {rtq_q[10:0], 1'b1};
        end else begin
          rtr_q <= rsh[11:0];
          rtq_q <= {rtq_q[10:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      union_q <= '0;
      match_q <= '0;
      bit_q   <= '0;
    end else begin
      if (cmd_i.accum) begin
        if (item_i.last_pixel) begin
          union_q <= '0;
          match_q <= '0;
        end else begin
          union_q <= union_n;
          match_q <= match_n;
        end
      end
      if (cmd_i.div_start) bit_q <= '0;
      else if (cmd_i.div_step) bit_q <= bit_q + 1'b1;
    end
  end

  // the last pixel is folded in combinationally: div_start latches the
  // folded counts while accum clears them in the same cycle
  // ---- scoring
  logic signed [8:0] pct_c;
  logic signed [8:0] pct_q;
  logic [11:0] dc, dr, dd;
  logic [3:0]  lay_d;
  logic [3:0]  bonus;

  always_comb begin
    dc = (qtr_q > rtr_q) ? qtr_q - rtr_q : rtr_q - qtr_q;
    dr = (qtq_q > rtq_q) ? qtq_q - rtq_q : rtq_q - qtq_q;
    dd = (dc > dr) ? dc : dr;
    unique case (dd[2:0])
      3'd0:    bonus = 4'd8;
      3'd1:    bonus = 4'd6;
      3'd2:    bonus = 4'd4;
      3'd3:    bonus = 4'd3;
      3'd4:    bonus = 4'd1;
      default: bonus = 4'd0;
    endcase
    if (sheet_columns_i == '0 || dd >= 12'(NearR)) bonus = 4'd0;
    lay_d = (ql_q > rl_q) ? 4'(ql_q - rl_q) : 4'(rl_q - ql_q);
    pct_c = $signed({2'b00, quo_q});
    if (!ql_q[3] && !rl_q[3] && ql_q != rl_q)
      pct_c = pct_c - $signed({1'b0, 8'(lay_d) * 8'(LayerCost)});
    pct_c = pct_c + $signed({5'b0, bonus});
  end

  // ---- top list, sorted descending, serial insert from the tail
  logic signed [8:0] top_s_q [MaxK];
  logic [CW-1:0]     top_c_q [MaxK];
  logic [KW:0]       fill_q;
  logic [KW:0]       pos_q;   // slot being considered
  logic              ins_done_c;
  logic [KW-1:0]     pi;

  assign pi = pos_q[KW-1:0];
  // pos_q is the slot receiving; its predecessor moves down if smaller
  assign ins_done_c = (pos_q == '0) || (top_s_q[pi - 1'b1] >= pct_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.score) pct_q <= pct_c;
    if (cmd_i.ins_step && pos_q < (KW+1)'(MaxK)) begin
      if (ins_done_c) begin
        top_s_q[pi] <= pct_q;
        top_c_q[pi] <= cat_q;
      end else begin
        top_s_q[pi] <= top_s_q[pi - 1'b1];
        top_c_q[pi] <= top_c_q[pi - 1'b1];
      end
    end
  end

  logic cand_c;
  assign cand_c = (pct_c >= $signed({2'b00, min_percent_i})) &&
                  ((fill_q < (KW+1)'(MaxK)) ||
                   (pct_c > top_s_q[KW'(MaxK-1)]));

  // ---- vote tallies
  logic [9:0]    w_q  [NumCat];
  logic [6:0]    pk_q [NumCat];
  logic          seen_q [NumCat];
  logic [KW:0]   vn_q;
  logic [KW:0]   klim;
  logic [CW:0]   pc_q;
  logic [9:0]    bw_q;
  logic [6:0]    bp_q;
  logic [CW-1:0] win_q;
  logic          fnd_q;
  logic [CW-1:0] vc;
  logic [CW-1:0] pcc;

  always_comb begin
    klim = (neighbours_i > 4'(MaxK)) ? (KW+1)'(MaxK) : (KW+1)'(neighbours_i);
    if (klim > fill_q) klim = fill_q;
    vc  = top_c_q[vn_q[KW-1:0]];
    pcc = pc_q[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      vn_q   <= '0;
      pc_q   <= '0;
      fnd_q  <= 1'b0;
      for (int i = 0; i < NumCat; i++) seen_q[i] <= 1'b0;
    end else begin
      if (cmd_i.score)
        pos_q <= (fill_q < (KW+1)'(MaxK)) ? fill_q : (KW+1)'(MaxK-1);
      else if (cmd_i.ins_step) begin
        if (ins_done_c) begin
          if (fill_q < (KW+1)'(MaxK)) fill_q <= fill_q + 1'b1;
        end else pos_q <= pos_q - 1'b1;
      end
      if (cmd_i.vote_clr) begin
        vn_q  <= '0;
        pc_q  <= '0;
        fnd_q <= 1'b0;
        for (int i = 0; i < NumCat; i++) seen_q[i] <= 1'b0;
      end else if (cmd_i.vote_add && vn_q < klim) begin
        seen_q[vc] <= 1'b1;
        vn_q <= vn_q + 1'b1;
      end else if (cmd_i.pick_step) begin
        pc_q <= pc_q + 1'b1;
        if (seen_q[pcc] && (!fnd_q || w_q[pcc] > bw_q ||
            (w_q[pcc] == bw_q && pk_q[pcc] > bp_q))) fnd_q <= 1'b1;
      end
      if (cmd_i.finish) fill_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vote_add && vn_q < klim) begin
      w_q[vc] <= (seen_q[vc] ? w_q[vc] : 10'd0) + 10'(top_s_q[vn_q[KW-1:0]]);
      if (!seen_q[vc] || 7'(top_s_q[vn_q[KW-1:0]]) > pk_q[vc])
        pk_q[vc] <= 7'(top_s_q[vn_q[KW-1:0]]);
    end
    if (cmd_i.pick_step && seen_q[pcc] && (!fnd_q || w_q[pcc] > bw_q ||
        (w_q[pcc] == bw_q && pk_q[pcc] > bp_q))) begin
      bw_q  <= w_q[pcc];
      bp_q  <= pk_q[pcc];
      win_q <= pcc;
    end
    if (cmd_i.finish) begin
      res_o.found           <= fnd_q;
      res_o.winner_category <= fnd_q ? 4'(win_q) : 4'd0;
      res_o.peak_percent    <= fnd_q ? $signed({1'b0, bp_q}) : -8'sd1;
    end
  end

  assign stat_o.skip      = skip_c;
  assign stat_o.cand      = cand_c;
  assign stat_o.ins_done  = ins_done_c;
  assign stat_o.div_done  = bit_q == 5'd17;
  assign stat_o.add_done  = vn_q >= klim;
  assign stat_o.pick_done = pc_q == (CW+1)'(NumCat-1);

endmodule

// ===== design/tkcv_ctrl.sv =====
// Controller for the tile category vote: sequences accumulate, divide,
// score, insert and vote. Uses tkcv_pkg; drives tkcv_datapath.
module tkcv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            last_pixel_i,
  input  logic            last_ref_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  tkcv_pkg::stat_t stat_i,
  output tkcv_pkg::cmd_t  cmd_o
);
  import tkcv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HOLD, S_DIV, S_SCORE, S_INS, S_VCLR, S_VADD, S_PICK, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic   vote_q;
  logic   acc;

  // the pixel word is latched upstream; S_HOLD folds it and scores on a last pixel
  assign in_stall_o = !(state_q == S_IDLE);
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.accum = 1'b0;
      S_HOLD:  begin
        cmd_o.div_start = last_pixel_i && !stat_i.skip;
        cmd_o.accum     = 1'b1;
      end
      S_DIV:   cmd_o.div_step = 1'b1;
      S_SCORE: cmd_o.score = 1'b1;
      S_INS:   cmd_o.ins_step = 1'b1;
      S_VCLR:  cmd_o.vote_clr = 1'b1;
      S_VADD:  cmd_o.vote_add = 1'b1;
      S_PICK:  cmd_o.pick_step = 1'b1;
      S_FIN:   cmd_o.finish = 1'b1;
      S_OUT:   cmd_o.accum = 1'b0;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vote_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (acc) state_q <= S_HOLD;
        S_HOLD: begin
          vote_q <= last_pixel_i && last_ref_i;
          if (!last_pixel_i) state_q <= S_IDLE;
          else if (stat_i.skip) state_q <= last_ref_i ? S_VCLR : S_IDLE;
          else state_q <= S_DIV;
        end
        S_DIV:   if (stat_i.div_done) state_q <= S_SCORE;
        S_SCORE: state_q <= stat_i.cand ? S_INS : (vote_q ? S_VCLR : S_IDLE);
        S_INS:   if (stat_i.ins_done) state_q <= vote_q ? S_VCLR : S_IDLE;
        S_VCLR:  state_q <= S_VADD;
        S_VADD:  if (stat_i.add_done) state_q <= S_PICK;
        S_PICK:  if (stat_i.pick_done) state_q <= S_FIN;
        S_FIN: begin
          state_q     <= S_OUT;
          out_valid_o <= 1'b1;
        end
        S_OUT: if (!out_stall_i) begin
          out_valid_o <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/tile_knn_category_vote_top.sv =====
// Top level of the tile category vote block: input word register, config
// registers, controller and datapath. Uses tkcv_pkg, tkcv_ctrl, tkcv_datapath.
//
// Usage: stream one query/reference pixel pair per input word. in_valid_i
// with in_stall_o low accepts a word. The pair is counted in the next cycle,
// and no new word is taken until it has been. On a reference's last pixel,
// unless it is skipped, the score takes a bit-serial divide (match*100/union
// and tile/columns share that loop), a scoring step and, for a candidate,
// up to 8 insertion steps into the top list. On the final reference the vote
// adds up to 8 entries and scans 16 categories, one a cycle, then presents
// one result word on out_valid_o; it holds until out_stall_i is low. No new
// word is taken while a result waits. Config writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) are taken at any edge, intended while idle.
// Reset clears counts, list fill and control; config returns to defaults.
module tile_knn_category_vote_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tkcv_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tkcv_pkg::out_word_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [11:0]         cfg_data_i
);
  import tkcv_pkg::*;

  in_word_t   item_q;
  cmd_t       cmd;
  stat_t      stat;
  logic [6:0]  min_pct_q;
  logic [3:0]  neigh_q;
  logic [11:0] cols_q;
  logic [10:0] pix_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pct_q <= 7'd60;
      neigh_q   <= 4'd3;
      cols_q    <= 12'd1;
      pix_q     <= 11'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMinPct: min_pct_q <= cfg_data_i[6:0];
        RegNeigh:  neigh_q   <= cfg_data_i[3:0];
        RegCols:   cols_q    <= cfg_data_i;
        RegPix:    pix_q     <= cfg_data_i[10:0];
        default:   pix_q     <= pix_q;
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) item_q <= in_data_i;
  end

  tkcv_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .last_pixel_i(item_q.last_pixel), .last_ref_i(item_q.last_ref),
    .out_valid_o, .out_stall_i, .stat_i(stat), .cmd_o(cmd)
  );

  tkcv_datapath u_dp (
    .clk_i, .rst_ni, .item_i(item_q), .cmd_i(cmd),
    .min_percent_i(min_pct_q), .neighbours_i(neigh_q),
    .sheet_columns_i(cols_q), .tile_pixels_i(pix_q),
    .stat_o(stat), .res_o(out_data_o)
  );

  // no word is taken while a result waits
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  // a waiting result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // abstain implies sentinel peak
  a_abstain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.peak_percent == -8'sd1)
    else $error("abstain without sentinel");

endmodule

// ===== tb/sv/tkcv_checker.sv =====
`timescale 1ns / 100ps
// Checker for the tile category vote block: watches both channels, predicts
// each vote result from accepted input words and compares. Uses tkcv_pkg.
module tkcv_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  tkcv_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  tkcv_pkg::out_word_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [11:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import tkcv_pkg::*;

  // shadow config
  int unsigned min_pct_q, neigh_q, cols_q, pix_q;
  // shadow state
  int unsigned union_q, match_q, fill_q;
  int          list_score[MaxK];
  int unsigned list_cat[MaxK];
  out_word_t   vote_queue[$];

  function automatic int unsigned adiff(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  // fold one pixel pair into union and match counts
  task automatic count_pair(input logic [31:0] q, input logic [31:0] r);
    int unsigned aq, ar;
    bit oq, orf, m;
    aq = q[31:24];
    ar = r[31:24];
    oq = aq >= OpaqueA;
    orf = ar >= OpaqueA;
    if (!oq && !orf) return;
    if (union_q < CountMax) union_q++;
    m = adiff(aq, ar) <= Tol;
    if (m && oq && orf) begin
      if (adiff(q[23:16], r[23:16]) > Tol) m = 0;
      if (adiff(q[15:8], r[15:8]) > Tol) m = 0;
      if (adiff(q[7:0], r[7:0]) > Tol) m = 0;
    end
    if (m && match_q < CountMax) match_q++;
  endtask

  // sorted insert, ties keep earlier arrivals
  task automatic list_insert(input int s, input int unsigned c);
    int unsigned pos, i;
    pos = 0;
    while (pos < fill_q && list_score[pos] >= s) pos++;
    if (pos >= MaxK) return;
    i = (fill_q < MaxK) ? fill_q : MaxK - 1;
    while (i > pos) begin
      list_score[i] = list_score[i-1];
      list_cat[i] = list_cat[i-1];
      i--;
    end
    list_score[pos] = s;
    list_cat[pos] = c;
    if (fill_q < MaxK) fill_q++;
  endtask

  task automatic score_ref(input in_word_t w);
    int unsigned qt, rt, d, dc, dr;
    int pct, rl, ql;
    qt = w.query_tile;
    rt = w.ref_tile;
    rl = w.ref_layer;
    ql = w.query_layer;
    if (qt == rt || union_q == 0 || union_q < pix_q * 32 / 256) return;
    pct = match_q * 100 / union_q;
    if (ql >= 0 && rl >= 0 && ql != rl) pct -= LayerCost * (ql > rl ? ql - rl : rl - ql);
    if (cols_q > 0) begin
      dc = adiff(qt % cols_q, rt % cols_q);
      dr = adiff(qt / cols_q, rt / cols_q);
      d = dc > dr ? dc : dr;
      if (d < NearR) pct += NearBonus * (NearR - int'(d)) / NearR;
    end
    if (pct >= int'(min_pct_q)) list_insert(pct, w.ref_category);
  endtask

  function automatic out_word_t tally_vote();
    int unsigned k, n, c, win;
    int weight[NumCat], peak[NumCat];
    bit seen[NumCat];
    int best_w, best_p;
    bit got;
    out_word_t r;
    k = neigh_q > MaxK ? MaxK : neigh_q;
    if (k > fill_q) k = fill_q;
    best_w = -1;
    best_p = -1;
    got = 0;
    win = 0;
    for (c = 0; c < NumCat; c++) begin
      weight[c] = 0;
      peak[c] = 0;
      seen[c] = 0;
    end
    for (n = 0; n < k; n++) begin
      c = list_cat[n];
      weight[c] += list_score[n];
      if (list_score[n] > peak[c]) peak[c] = list_score[n];
      seen[c] = 1;
    end
    for (c = 0; c < NumCat; c++) begin
      if (seen[c] && (weight[c] > best_w || (weight[c] == best_w && peak[c] > best_p))) begin
        best_w = weight[c];
        best_p = peak[c];
        win = c;
        got = 1;
      end
    end
    r.found = got;
    r.winner_category = got ? win[3:0] : '0;
    r.peak_percent = got ? 8'(best_p) : -8'sd1;
    return r;
  endfunction

  // watch channels and configuration
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pct_q = 60;
      neigh_q = 3;
      cols_q = 1;
      pix_q = 256;
      union_q = 0;
      match_q = 0;
      fill_q = 0;
      fail_count_o = 0;
      vote_queue.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (vote_queue.size() == 0) begin
          $display("%0t: unexpected word, got %p", $time, out_data_i);
          fail_count_o++;
        end else begin
          out_word_t e;
          e = vote_queue.pop_front();
          if (e.found !== out_data_i.found || e.winner_category !== out_data_i.winner_category
              || e.peak_percent !== out_data_i.peak_percent) begin
            $display("%0t: mismatch, expected %p, got %p", $time, e, out_data_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMinPct: min_pct_q = cfg_data_i[6:0];
          RegNeigh:  neigh_q = cfg_data_i[3:0];
          RegCols:   cols_q = cfg_data_i[11:0];
          RegPix:    pix_q = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        count_pair(in_data_i.query_pixel, in_data_i.ref_pixel);
        if (in_data_i.last_pixel) begin
          score_ref(in_data_i);
          union_q = 0;
          match_q = 0;
          if (in_data_i.last_ref) begin
            vote_queue.insert(vote_queue.size(), tally_vote());
            fill_q = 0;
          end
        end
      end
      pending_o = vote_queue.size();
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for tile_knn_category_vote_top: drives pixel-pair words,
// config writes and output stalls; the verdict comes from tkcv_checker.
module testbench;
  import tkcv_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_word_t  in_data;
  out_word_t out_data;
  logic      cfg_we;
  logic [1:0]  cfg_idx;
  logic [11:0] cfg_data;
  int        fail_count, pending;
  int        in_idle_pct, out_idle_pct;
  longint    cycle_count;

  tile_knn_category_vote_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  tkcv_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 600000) begin
        $display("tile_knn_category_vote_top verification failed");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // send one word; random idle gap first, valid stays up until the next call
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned v);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= v[11:0];
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pixel(input logic [31:0] base, input int mode);
    logic [31:0] p;
    if (mode == 0) return $urandom;
    p = base;
    p[31:24] = base[31:24] + 8'($urandom_range(40)) - 8'd20;
    p[23:16] = base[23:16] + 8'($urandom_range(40)) - 8'd20;
    p[15:8]  = base[15:8] + 8'($urandom_range(40)) - 8'd20;
    p[7:0]   = base[7:0] + 8'($urandom_range(40)) - 8'd20;
    return p;
  endfunction

  // one reference tile: npix pairs, close to the query pixels or not
  task automatic send_ref(input int npix, input logic [11:0] qt, input logic [11:0] rt,
                          input logic [3:0] cat, input logic [3:0] ql, input logic [3:0] rl,
                          input bit last_ref, input int mode);
    in_word_t w;
    for (int i = 0; i < npix; i++) begin
      w.query_pixel = $urandom;
      if ($urandom_range(3) != 0) w.query_pixel[31] = 1;
      w.ref_pixel = rand_pixel(w.query_pixel, mode);
      w.query_tile = qt;
      w.ref_tile = rt;
      w.ref_category = cat;
      w.ref_layer = rl;
      w.query_layer = ql;
      w.last_pixel = (i == npix - 1);
      w.last_ref = (i == npix - 1) ? last_ref : $urandom_range(1);
      send_word(w);
    end
  endtask

  function automatic logic [3:0] rand_layer();
    int v;
    v = $urandom_range(9);
    if (v >= 6) return 4'($urandom);
    return 4'(v - 1);
  endfunction

  // one query: one or more references then the vote; returns the words sent
  task automatic send_query(input int npix, input int max_refs, output int items);
    logic [11:0] qt, rt;
    logic [3:0] ql;
    int nrefs;
    qt = $urandom_range(1) ? 12'($urandom_range(40)) : 12'($urandom);
    ql = rand_layer();
    nrefs = $urandom_range(1, max_refs);
    items = npix * nrefs;
    for (int r = 0; r < nrefs; r++) begin
      case ($urandom_range(5))
        0: rt = qt;
        1: rt = $urandom;
        default: rt = qt + 12'($urandom_range(8)) - 12'd4;
      endcase
      send_ref(npix, qt, rt, 4'($urandom_range(15) & ($urandom_range(1) ? 4'h3 : 4'hF)),
               ql, $urandom_range(2) ? ql : rand_layer(), r == nrefs - 1,
               $urandom_range(4) != 0);
    end
  endtask

  initial begin
    in_word_t w;
    int sent;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_idx = RegMinPct;
    cfg_data = '0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: small tiles, extreme pixels, self and empty references
    write_reg(RegPix, 1);
    write_reg(RegMinPct, 0);
    w = '0;
    w.query_pixel = 32'hFFFF_FFFF;
    w.ref_pixel = 32'hFFFF_FFFF;
    w.query_tile = 12'hFFF;
    w.ref_tile = 12'hFFE;
    w.ref_category = 4'hF;
    w.ref_layer = 4'sd7;
    w.query_layer = -4'sd8;
    w.last_pixel = 1;
    send_word(w);
    w.ref_tile = 12'hFFF;
    send_word(w);                 // self reference
    w.query_pixel = 32'h7F00_0000;
    w.ref_pixel = 32'h0000_0000;
    w.ref_tile = 12'h000;
    send_word(w);                 // empty union
    w.query_pixel = 32'h8012_1212;
    w.ref_pixel = 32'h9200_0000;
    w.last_pixel = 0;
    w.last_ref = 1;               // orphan last_ref
    send_word(w);
    w.query_layer = 4'sd0;
    w.ref_layer = 4'sd4;
    w.query_tile = 12'd0;
    w.ref_tile = 12'd1;
    w.last_pixel = 1;
    send_word(w);
    drain();
    write_reg(RegNeigh, 0);
    send_ref(2, 5, 6, 3, 1, 1, 1, 1);
    drain();
    write_reg(RegNeigh, 15);
    write_reg(RegCols, 0);
    write_reg(RegMinPct, 108);
    send_ref(1, 5, 6, 3, -1, 2, 0, 1);
    send_ref(1, 5, 7, 4, 2, 2, 1, 1);
    drain();
    write_reg(RegCols, 4095);
    write_reg(RegMinPct, 127);
    send_ref(1, 5, 6, 3, 2, 2, 1, 1);
    drain();

    // random phases under differing settings
    for (int ph = 0; ph < 9; ph++) begin
      in_idle_pct = (ph < 3) ? 23 : (ph < 6) ? 50 : 0;
      out_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 23 : 0;
      case (ph % 3)
        0: begin
          write_reg(RegMinPct, 0);
          write_reg(RegNeigh, 8);
          write_reg(RegCols, 1);
          write_reg(RegPix, 8);
        end
        1: begin
          write_reg(RegMinPct, $urandom_range(30, 90));
          write_reg(RegNeigh, $urandom_range(1, 15));
          write_reg(RegCols, $urandom_range(2, 12));
          write_reg(RegPix, $urandom_range(1, 40));
        end
        default: begin
          write_reg(RegMinPct, $urandom_range(0, 108));
          write_reg(RegNeigh, 1);
          write_reg(RegCols, $urandom_range(1) ? 4095 : 0);
          write_reg(RegPix, $urandom_range(1) ? 1024 : 2047);
        end
      endcase
      sent = 0;
      while (sent < 95) begin
        int np, cnt;
        np = (ph % 3 == 2 && sent == 0) ? $urandom_range(130, 170) : $urandom_range(1, 4);
        send_query(np, (np > 4) ? 1 : 10, cnt);
        sent += cnt;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tile_knn_category_vote_top verification clean");
    end else begin
      $display("tile_knn_category_vote_top verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/tkcv_pkg.sv
design/tkcv_datapath.sv
design/tkcv_ctrl.sv
design/tile_knn_category_vote_top.sv
tb/sv/tkcv_checker.sv
tb/sv/testbench.sv
